// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when cond holds, prop holds on the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when cond holds, prop holds on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/brx_pkg.sv =====
// Package with constants, control word type and helper functions of the bounded random block.
`default_nettype none

package brx_pkg;

    // Xorshift64 shift amounts.
    localparam int ShiftA = 13;
    localparam int ShiftB = 7;
    localparam int ShiftC = 17;

    // Bytes in one generator word, also the "word used up" offset.
    localparam logic [3:0] WORD_BYTES = 4'd8;

    // Width codes of a request.
    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    // Microprogram step addresses.
    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_PREP = 2'd1;
    localparam logic [1:0] STEP_DRAW = 2'd2;
    localparam logic [1:0] STEP_EMIT = 2'd3;

    // Jump condition codes.
    localparam logic [1:0] COND_ACCEPT   = 2'd0;
    localparam logic [1:0] COND_BAD      = 2'd1;
    localparam logic [1:0] COND_DRAW_OK  = 2'd2;
    localparam logic [1:0] COND_OUT_FREE = 2'd3;

    // One control word of the microprogram.
    typedef struct packed {
        logic       in_ready;
        logic       prep;
        logic       draw;
        logic       emit;
        logic [1:0] cond;
        logic [1:0] tgt_true;
        logic [1:0] tgt_false;
    } t_ctrl;

    // Read-only microprogram: one control word per step.
    function automatic t_ctrl ucode(input logic [1:0] step);
        t_ctrl w;
        w = '0;
        unique case (step)
            STEP_IDLE: begin
                w.in_ready  = 1'b1;
                w.cond      = COND_ACCEPT;
                w.tgt_true  = STEP_PREP;
                w.tgt_false = STEP_IDLE;
            end
            STEP_PREP: begin
                w.prep      = 1'b1;
                w.cond      = COND_BAD;
                w.tgt_true  = STEP_EMIT;
                w.tgt_false = STEP_DRAW;
            end
            STEP_DRAW: begin
                w.draw      = 1'b1;
                w.cond      = COND_DRAW_OK;
                w.tgt_true  = STEP_EMIT;
                w.tgt_false = STEP_DRAW;
            end
            STEP_EMIT: begin
                w.emit      = 1'b1;
                w.cond      = COND_OUT_FREE;
                w.tgt_true  = STEP_IDLE;
                w.tgt_false = STEP_EMIT;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    // One xorshift64 advance.
    function automatic logic [63:0] xorshift64(input logic [63:0] w_in);
        logic [63:0] w;
        w = w_in;
        w = w ^ (w << ShiftA);
        w = w ^ (w >> ShiftB);
        w = w ^ (w << ShiftC);
        return w;
    endfunction

    // All-ones mask of the entry width.
    function automatic logic [63:0] width_mask(input logic [1:0] wc);
        logic [63:0] m;
        unique case (wc)
            WC_8:    m = 64'h0000_0000_0000_00FF;
            WC_16:   m = 64'h0000_0000_0000_FFFF;
            WC_32:   m = 64'h0000_0000_FFFF_FFFF;
            WC_64:   m = 64'hFFFF_FFFF_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bounded_random_from_xorshift_top.sv =====
// An input transfer passes the prep, draw and emit steps before a valid result is registered;
// a new request is taken only in the idle step, once the last result has left the emit step.
// Each rejected bounded draw repeats the draw step on the byte window of the generator.
// A bounded request with a zero bound skips the draw and goes from prep to emit.
// Reset (synchronous, active low) loads generator word 1, marks the word used up
// and returns the sequencer to its idle step with no result pending.
`default_nettype none

module bounded_random_from_xorshift_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: seed register write.
    input  wire logic        i_cfg_we,
    input  wire logic [63:0] i_cfg_wdata,
    // Request stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,  // [0] mode, [2:1] width_code, [66:3] bound, rest zero
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,  // [63:0] value
    output logic             o_m_tuser   // [0] bad_request
);

    brx_pkg::t_ctrl ctrl;

    logic [1:0]  r_step, n_step;
    logic [63:0] r_gen, n_gen;
    logic [3:0]  r_off, n_off;

    logic        r_req_mode;
    logic [1:0]  r_req_wc;
    logic [63:0] r_req_bound;

    logic        r_mode;
    logic [1:0]  r_dwc;
    logic [63:0] r_bound;
    logic [63:0] r_mask;
    logic [63:0] r_num;
    logic        r_bad;

    logic        r_out_valid;
    logic [63:0] r_out_value;
    logic        r_out_bad;

    logic        in_xfer;
    logic        out_free;
    logic        cond_true;

    logic [63:0] prep_bound;
    logic [1:0]  prep_wc;
    logic [63:0] prep_mask;
    logic        prep_bad;

    logic [3:0]   off_eff;
    logic [63:0]  gen_next;
    logic [127:0] window;
    logic [63:0]  draw_val;
    logic [4:0]   draw_nb;
    logic [4:0]   draw_sum;
    logic         draw_ok;

    // Current control word from the microprogram.
    assign ctrl     = brx_pkg::ucode(r_step);
    assign in_xfer  = i_s_tvalid && ctrl.in_ready;
    assign out_free = !r_out_valid || i_m_tready;

    // Request preparation: truncate the bound; in bounded mode narrow the width and smear the mask.
    always_comb begin
        logic [63:0] m;
        prep_bound = r_req_bound & brx_pkg::width_mask(r_req_wc);
        prep_bad   = r_req_mode && (prep_bound == 64'd0);
        prep_wc    = r_req_wc;
        if (prep_wc == brx_pkg::WC_64 && prep_bound < 64'h0000_0000_FFFF_FFFF) begin
            prep_wc = brx_pkg::WC_32;
        end
        if (prep_wc == brx_pkg::WC_32 && prep_bound < 64'h0000_0000_0000_FFFF) begin
            prep_wc = brx_pkg::WC_16;
        end
        if (prep_wc == brx_pkg::WC_16 && prep_bound <= 64'h0000_0000_0000_00FF) begin
            prep_wc = brx_pkg::WC_8;
        end
        m = prep_bound;
        m = m | (m >> 32);
        m = m | (m >> 16);
        m = m | (m >> 8);
        m = m | (m >> 4);
        m = m | (m >> 2);
        m = m | (m >> 1);
        prep_mask = r_req_mode ? m : brx_pkg::width_mask(r_req_wc);
        if (!r_req_mode) begin
            prep_wc = r_req_wc;
        end
    end

    // Draw: take the next bytes from the current word and, past its end, the next word.
    always_comb begin
        off_eff  = (r_off > brx_pkg::WORD_BYTES) ? brx_pkg::WORD_BYTES : r_off;
        gen_next = brx_pkg::xorshift64(r_gen);
        window   = {gen_next, r_gen} >> {off_eff, 3'b000};
        draw_val = window[63:0] & brx_pkg::width_mask(r_dwc) & r_mask;
        draw_nb  = 5'd1 << r_dwc;
        draw_sum = {1'b0, off_eff} + draw_nb;
        draw_ok  = !r_mode || (draw_val < r_bound);
    end

    // Jump condition and next step.
    always_comb begin
        unique case (ctrl.cond)
            brx_pkg::COND_ACCEPT:   cond_true = in_xfer;
            brx_pkg::COND_BAD:      cond_true = prep_bad;
            brx_pkg::COND_DRAW_OK:  cond_true = draw_ok;
            brx_pkg::COND_OUT_FREE: cond_true = out_free;
            default:                cond_true = 1'b0;
        endcase
        n_step = cond_true ? ctrl.tgt_true : ctrl.tgt_false;
    end

    // Generator word and byte offset; a seed write restarts the stream.
    always_comb begin
        n_gen = r_gen;
        n_off = r_off;
        if (i_cfg_we) begin
            n_gen = i_cfg_wdata;
            n_off = brx_pkg::WORD_BYTES;
        end else if (ctrl.draw) begin
            if (draw_sum > 5'd8) begin
                n_gen = gen_next;
                n_off = 4'(draw_sum - 5'd8);
            end else begin
                n_off = draw_sum[3:0];
            end
        end
    end

    // Control and generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= brx_pkg::STEP_IDLE;
            r_gen       <= 64'd1;
            r_off       <= brx_pkg::WORD_BYTES;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_gen  <= n_gen;
            r_off  <= n_off;
            if (ctrl.emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers driven by the control word.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req_mode  <= i_s_tdata[0];
            r_req_wc    <= i_s_tdata[2:1];
            r_req_bound <= i_s_tdata[66:3];
        end
        if (ctrl.prep) begin
            r_mode  <= r_req_mode;
            r_dwc   <= prep_wc;
            r_bound <= prep_bound;
            r_mask  <= prep_mask;
            r_bad   <= prep_bad;
            r_num   <= 64'd0;
        end
        if (ctrl.draw) begin
            r_num <= draw_val;
        end
        if (ctrl.emit && out_free) begin
            r_out_value <= r_num;
            r_out_bad   <= r_bad;
        end
    end

    assign o_s_tready = ctrl.in_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_bad;

endmodule

`default_nettype wire

// ===== hw/rtl/brx_checker.sv =====
// Port-level checker of the bounded random block and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module brx_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [63:0] o_m_tdata,
    input wire logic        o_m_tuser
);

    // A stalled result keeps its data.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // A flagged request always carries a zero value.
    `ASSERT_IMPLY(a_bad_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata == 64'd0)

    // The block works on one request at a time: it is busy right after a transfer.
    `ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

bind bounded_random_from_xorshift_top brx_checker u_brx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
